// ----- design/rbst_pkg.sv -----
package rbst_pkg;

  localparam int unsigned FACE_COUNT_DEF = 256;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned NUM_W          = 34;  // exact padded bound minus origin
  localparam int unsigned DIV_LAT        = 35;  // abs, range check, 32 quotient bits, saturate
  localparam int unsigned BOX_W          = 96;

  typedef enum logic [1:0] {
    KIND_LOAD_MIN = 2'd0,
    KIND_LOAD_MAX = 2'd1,
    KIND_QUERY    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAD_MARGIN   = 4'd0,
    CFG_BOXES_LOADED = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         face_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] max_t;
  } in_item_t;

  typedef struct packed {
    logic       reaches;
    logic [7:0] queried_face;
  } res_item_t;

  // Per-query info that rides alongside the dividers.
  typedef struct packed {
    logic [7:0]         face;
    logic               forced;
    logic               forced_val;
    logic signed [31:0] max_t;
    logic [2:0]         dzero;
    logic [2:0]         contained;
  } side_t;

endpackage

// ----- design/rbst_box_mem.sv -----
module rbst_box_mem import rbst_pkg::*; #(
  parameter int unsigned DEPTH = FACE_COUNT_DEF,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [BOX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [BOX_W-1:0] rdata_o
);

  logic [BOX_W-1:0] mem [DEPTH];
  logic [BOX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rbst_div.sv -----
// Saturating Q16.16 quotient (num * 2^16) / den, truncated toward zero.
// One quotient bit per stage.
module rbst_div import rbst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [31:0]      den_i,
  output logic signed [31:0]      quo_o
);

  // stage A: magnitudes and sign
  logic [NUM_W-1:0] nmag_q;
  logic [31:0]      dmag_a_q;
  logic             neg_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      dmag_a_q <= den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_a_q  <= num_i[NUM_W-1] ^ den_i[31];
    end
  end

  // step registers; index 0 is the range-check stage
  logic [31:0] rem_q  [33];
  logic [31:0] low_q  [33];
  logic [31:0] quo_q  [33];
  logic [31:0] dmag_q [33];
  logic        neg_q  [33];
  logic        ovf_q  [33];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // quotient >= 2^32 exactly when floor(N / 2^32) >= den
      ovf_q[0]  <= {14'b0, nmag_q[NUM_W-1:16]} >= dmag_a_q;
      rem_q[0]  <= {14'b0, nmag_q[NUM_W-1:16]};
      low_q[0]  <= {nmag_q[15:0], 16'b0};
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag_a_q;
      neg_q[0]  <= neg_a_q;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_step
    logic [33:0] trial;
    logic        ge;
    assign trial = {1'b0, rem_q[k], low_q[k][31]} - {2'b0, dmag_q[k]};
    assign ge    = !trial[33];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial[31:0] : {rem_q[k][30:0], low_q[k][31]};
        low_q[k+1]  <= {low_q[k][30:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][30:0], ge};
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  logic signed [31:0] sat_d, sat_q;

  always_comb begin
    if (ovf_q[32]) begin
      sat_d = neg_q[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_q[32]) begin
      sat_d = (quo_q[32] > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-quo_q[32]);
    end else begin
      sat_d = quo_q[32][31] ? 32'sh7fff_ffff : 32'(quo_q[32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= sat_d;
    end
  end

  assign quo_o = sat_q;

  // rem_q[32], low_q[32] and dmag_q[32] are the last step's leftovers
  logic unused_tail;
  assign unused_tail = ^{rem_q[32], low_q[32], dmag_q[32]};

endmodule

// ----- design/rbst_merge.sv -----
// Interval narrowing, one axis per stage; last stage is the result register.
module rbst_merge import rbst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic signed [31:0] t_lo_i [3],
  input  logic signed [31:0] t_hi_i [3],
  output logic               valid_o,
  output res_item_t          item_o
);

  typedef struct packed {
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
    logic               hit;
  } ival_t;

  function automatic ival_t axis_step(ival_t cur, logic signed [31:0] ta,
                                      logic signed [31:0] tb, logic dz, logic ins);
    ival_t              nxt;
    logic signed [31:0] t1, t2;
    nxt = cur;
    t1  = (ta > tb) ? tb : ta;
    t2  = (ta > tb) ? ta : tb;
    if (cur.hit) begin
      if (dz) begin
        nxt.hit = ins;
      end else begin
        nxt.tmin = (t1 > cur.tmin) ? t1 : cur.tmin;
        nxt.tmax = (t2 < cur.tmax) ? t2 : cur.tmax;
        nxt.hit  = nxt.tmin <= nxt.tmax;
      end
    end
    return nxt;
  endfunction

  logic               v0_q, v1_q, out_valid_q;
  side_t              side0_q, side1_q;
  ival_t              iv0_q, iv1_q, iv0_d, iv1_d, iv2_d;
  logic signed [31:0] lo0_q [2];
  logic signed [31:0] hi0_q [2];
  logic signed [31:0] lo1_q, hi1_q;
  res_item_t          out_item_q;
  ival_t              iv_init;

  assign iv_init = '{tmin: 32'sd0, tmax: side_i.max_t, hit: 1'b1};
  assign iv0_d = axis_step(iv_init, t_lo_i[0], t_hi_i[0], side_i.dzero[0],
                           side_i.contained[0]);
  assign iv1_d = axis_step(iv0_q, lo0_q[0], hi0_q[0], side0_q.dzero[1],
                           side0_q.contained[1]);
  assign iv2_d = axis_step(iv1_q, lo1_q, hi1_q, side1_q.dzero[2],
                           side1_q.contained[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v0_q        <= valid_i;
      v1_q        <= v0_q;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side0_q  <= side_i;
      iv0_q    <= iv0_d;
      lo0_q[0] <= t_lo_i[1];
      hi0_q[0] <= t_hi_i[1];
      lo0_q[1] <= t_lo_i[2];
      hi0_q[1] <= t_hi_i[2];
      side1_q  <= side0_q;
      iv1_q    <= iv1_d;
      lo1_q    <= lo0_q[1];
      hi1_q    <= hi0_q[1];
      out_item_q.reaches      <= side1_q.forced ? side1_q.forced_val : iv2_d.hit;
      out_item_q.queried_face <= side1_q.face;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_item_q;

endmodule

// ----- design/ray_box_slab_test.sv -----
// Channel | Dir | Handshake               | Beat
// --------+-----+-------------------------+-------------------------------------
// in      | in  | in_valid_i / in_ready_o | in_item_t: load min/max or ray query
// out     | out | out_valid_o/out_ready_i | res_item_t: one per query
// cfg     | in  | cfg_valid_i/cfg_ready_o | register index + data, always ready
//
// One beat per cycle while the pipe is not frozen, loads and queries mixed
// freely. A query's result passes the table read, padded bounds, numerators,
// 35 divider stages and three interval stages ending in the result register.
// Six dividers (lo and hi slab per axis) run in lockstep; they set the depth.
// The whole pipe freezes only while a result sits unaccepted on out.
// No clearing pass after reset: box entries are undefined until loaded.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int unsigned FACE_COUNT = FACE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (FACE_COUNT > 1) ? $clog2(FACE_COUNT) : 1;

  // ---------------- config registers ----------------
  logic [30:0] pad_q;
  logic        loaded_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q    <= '0;
      loaded_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAD_MARGIN:   pad_q    <= cfg_data_i[30:0];
        CFG_BOXES_LOADED: loaded_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  logic adv, accept, res_valid;

  assign adv        = !res_valid || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // ---------------- stage 0: table access ----------------
  logic [31:0]      face_ext;
  logic             in_range, is_query, we_min, we_max, rd_en;
  logic [AW-1:0]    addr;
  logic [BOX_W-1:0] wdata, min_rd, max_rd;

  assign face_ext = {24'b0, in_item_i.face_index};
  assign in_range = face_ext < 32'(FACE_COUNT);
  assign addr     = face_ext[AW-1:0];
  assign is_query = in_item_i.kind == KIND_QUERY;
  assign we_min   = accept && in_range && (in_item_i.kind == KIND_LOAD_MIN);
  assign we_max   = accept && in_range && (in_item_i.kind == KIND_LOAD_MAX);
  assign rd_en    = accept && is_query;
  assign wdata    = {in_item_i.coord_z, in_item_i.coord_y, in_item_i.coord_x};

  rbst_box_mem #(.DEPTH(FACE_COUNT), .AW(AW)) u_min_mem (
    .clk_i, .we_i(we_min), .waddr_i(addr), .wdata_i(wdata),
    .re_i(rd_en), .raddr_i(addr), .rdata_o(min_rd)
  );

  rbst_box_mem #(.DEPTH(FACE_COUNT), .AW(AW)) u_max_mem (
    .clk_i, .we_i(we_max), .waddr_i(addr), .wdata_i(wdata),
    .re_i(rd_en), .raddr_i(addr), .rdata_o(max_rd)
  );

  // ---------------- stage 1: query payload beside read data ----------------
  logic               p1_valid_q;
  side_t              p1_side_q;
  logic signed [31:0] p1_org_q [3];
  logic signed [31:0] p1_dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= accept && is_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_side_q.face       <= in_item_i.face_index;
      p1_side_q.forced     <= !loaded_q || !in_range;
      p1_side_q.forced_val <= !loaded_q;
      p1_side_q.max_t      <= in_item_i.max_t;
      p1_side_q.dzero      <= '0;
      p1_side_q.contained  <= '0;
      p1_org_q[0] <= in_item_i.coord_x;
      p1_org_q[1] <= in_item_i.coord_y;
      p1_org_q[2] <= in_item_i.coord_z;
      p1_dir_q[0] <= in_item_i.dir_x;
      p1_dir_q[1] <= in_item_i.dir_y;
      p1_dir_q[2] <= in_item_i.dir_z;
    end
  end

  // ---------------- stage 2: padded bounds (exact) ----------------
  logic                    p2_valid_q;
  side_t                   p2_side_q;
  logic signed [31:0]      p2_org_q [3];
  logic signed [31:0]      p2_dir_q [3];
  logic signed [NUM_W-1:0] p2_lo_q  [3];
  logic signed [NUM_W-1:0] p2_hi_q  [3];
  logic signed [NUM_W-1:0] pad_ext;

  assign pad_ext = $signed({3'b0, pad_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (adv) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_bounds
    logic signed [31:0] mn, mx;
    assign mn = min_rd[32*a +: 32];
    assign mx = max_rd[32*a +: 32];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p2_lo_q[a]  <= NUM_W'(mn) - pad_ext;
        p2_hi_q[a]  <= NUM_W'(mx) + pad_ext;
        p2_org_q[a] <= p1_org_q[a];
        p2_dir_q[a] <= p1_dir_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_side_q <= p1_side_q;
    end
  end

  // ---------------- stage 3: numerators, containment ----------------
  logic                    p3_valid_q;
  side_t                   p3_side_q, p3_side_d;
  logic signed [31:0]      p3_dir_q [3];
  logic signed [NUM_W-1:0] p3_nlo_q [3];
  logic signed [NUM_W-1:0] p3_nhi_q [3];
  logic [2:0]              dzero_d, inside_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (adv) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_num
    logic signed [NUM_W-1:0] org_ext;
    assign org_ext     = NUM_W'(p2_org_q[a]);
    assign dzero_d[a]  = p2_dir_q[a] == 32'sd0;
    assign inside_d[a] = !(org_ext < p2_lo_q[a] || org_ext > p2_hi_q[a]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p3_nlo_q[a] <= p2_lo_q[a] - org_ext;
        p3_nhi_q[a] <= p2_hi_q[a] - org_ext;
        p3_dir_q[a] <= p2_dir_q[a];
      end
    end
  end

  always_comb begin
    p3_side_d           = p2_side_q;
    p3_side_d.dzero     = dzero_d;
    p3_side_d.contained = inside_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_side_q <= p3_side_d;
    end
  end

  // ---------------- dividers, side info in lockstep ----------------
  logic signed [31:0] t_lo [3];
  logic signed [31:0] t_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbst_div u_div_lo (
      .clk_i, .en_i(adv), .num_i(p3_nlo_q[a]), .den_i(p3_dir_q[a]), .quo_o(t_lo[a])
    );
    rbst_div u_div_hi (
      .clk_i, .en_i(adv), .num_i(p3_nhi_q[a]), .den_i(p3_dir_q[a]), .quo_o(t_hi[a])
    );
  end

  logic [DIV_LAT-1:0] dv_q;
  side_t              dside_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (adv) begin
      dv_q <= {dv_q[DIV_LAT-2:0], p3_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= p3_side_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dside_q[i] <= dside_q[i-1];
      end
    end
  end

  // ---------------- interval narrowing and result register ----------------
  rbst_merge u_merge (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(dv_q[DIV_LAT-1]), .side_i(dside_q[DIV_LAT-1]),
    .t_lo_i(t_lo), .t_hi_i(t_hi),
    .valid_o(res_valid), .item_o(out_item_o)
  );

  assign out_valid_o = res_valid;

endmodule

// ----- design/rbst_checker.sv -----
module rbst_checker import rbst_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_item_t              in_item_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input res_item_t             out_item_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic unused_in;
  assign unused_in = ^{in_valid_i, in_item_i, cfg_valid_i, cfg_index_i, cfg_data_i};

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // an empty result slot never blocks input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // taking a result lets a new beat in the same cycle
  a_drain_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while result taken");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);

// ----- tb/ray_box_slab_test_tb.sv -----
module ray_box_slab_test_tb;
  import rbst_pkg::*;

  // A query beat gives one result; loads give no result.
  localparam int PIPE_LAT = 41;
  localparam int HOLD_OFF = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  res_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_box_slab_test uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Shadow of the box table and registers.
  logic signed [31:0] lo_box [256][3];
  logic signed [31:0] hi_box [256][3];
  bit                 face_loaded [256];
  logic [30:0]        pad_q;
  bit                 tbl_valid;

  res_item_t answers_due[$];
  int        mismatches = 0;
  int        answers_seen = 0;
  int        queries_sent = 0;
  int        loads_sent = 0;
  bit        stall_long = 1'b0;
  bit        out_done = 1'b0;

  // Saturating Q16.16 slab parameter: (num * 65536) / dir toward zero.
  function automatic longint slab_t(longint num, longint dvs);
    longint q;
    q = (num * 65536) / dvs;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit ray_reaches(in_item_t it);
    longint org [3];
    longint dv [3];
    longint lo, hi, t1, t2, sw, tmin, tmax;
    bit hit;
    org[0] = it.coord_x; org[1] = it.coord_y; org[2] = it.coord_z;
    dv[0] = it.dir_x;    dv[1] = it.dir_y;    dv[2] = it.dir_z;
    if (!tbl_valid) return 1'b1;
    tmin = 0;
    tmax = it.max_t;
    hit = 1'b1;
    for (int a = 0; a < 3 && hit; a++) begin
      lo = longint'(lo_box[it.face_index][a]) - longint'(pad_q);
      hi = longint'(hi_box[it.face_index][a]) + longint'(pad_q);
      if (dv[a] == 0) begin
        hit = !(org[a] < lo || org[a] > hi);
      end else begin
        t1 = slab_t(lo - org[a], dv[a]);
        t2 = slab_t(hi - org[a], dv[a]);
        if (t1 > t2) begin
          sw = t1; t1 = t2; t2 = sw;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        hit = tmin <= tmax;
      end
    end
    return hit;
  endfunction

  // Update shadow state for an accepted beat, queue any answer.
  task automatic note_beat(in_item_t it);
    res_item_t r;
    case (it.kind)
      KIND_LOAD_MIN, KIND_LOAD_MAX: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [31:0] c;
          c = (a == 0) ? it.coord_x : (a == 1) ? it.coord_y : it.coord_z;
          if (it.kind == KIND_LOAD_MIN) lo_box[it.face_index][a] = c;
          else hi_box[it.face_index][a] = c;
        end
        face_loaded[it.face_index] = 1'b1;
        loads_sent++;
      end
      KIND_QUERY: begin
        r.reaches = ray_reaches(it);
        r.queried_face = it.face_index;
        answers_due.push_back(r);
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  // Valid stays up after the beat so the next one can follow with no gap;
  // callers drop it before any wait.
  task automatic send_beat(in_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    note_beat(it);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PAD_MARGIN) pad_q = val[30:0];
    else tbl_valid = val[0];
  endtask

  // Block must be idle before a register write: drain, then wait out a load.
  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Random coordinate: mostly modest values, sometimes full range or zero.
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sd0;
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic [7:0] rnd_face();
    int k;
    do k = $urandom_range(0, 255); while (!face_loaded[k]);
    return k[7:0];
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 19);
    it.kind = (pick < 3) ? KIND_LOAD_MIN : (pick < 6) ? KIND_LOAD_MAX
            : (pick == 6) ? 2'd3 : KIND_QUERY;
    it.face_index = (it.kind == KIND_QUERY) ? rnd_face() : 8'($urandom_range(0, 255));
    it.coord_x = rnd_val(); it.coord_y = rnd_val(); it.coord_z = rnd_val();
    it.dir_x = ($urandom_range(0, 3) == 0) ? 32'sd0 : rnd_val();
    it.dir_y = ($urandom_range(0, 3) == 0) ? 32'sd0 : rnd_val();
    it.dir_z = ($urandom_range(0, 3) == 0) ? 32'sd0 : rnd_val();
    it.max_t = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000);
    // A load must not leave one corner of a queried face undefined: load both.
    return it;
  endfunction

  // Directed rows; expect_hit < 0 means "use the predictor".
  typedef struct {
    in_item_t it;
    int       expect_hit;
  } row_t;

  function automatic in_item_t mk(kind_e k, logic [7:0] f,
                                  logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                  logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                  logic [31:0] mt);
    in_item_t it;
    it.kind = k; it.face_index = f;
    it.coord_x = cx; it.coord_y = cy; it.coord_z = cz;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz; it.max_t = mt;
    return it;
  endfunction

  // Output side: random ready, one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    while (!out_done) begin
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        stall_long = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker, sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat face=%0d", out_item.queried_face);
      end else begin
        res_item_t e;
        e = answers_due.pop_front();
        if (e !== out_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected reaches=%0b face=%0d, got reaches=%0b face=%0d",
                     e.reaches, e.queried_face, out_item.reaches, out_item.queried_face);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    in_item_t it;
    int gap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pad_q = '0; tbl_valid = 1'b0;

    // Not loaded: any query answers 1, even on never-loaded faces.
    rows.push_back('{mk(KIND_QUERY, 8'd0, 0, 0, 0, 0, 0, 0, 32'h8000_0000), 1});
    rows.push_back('{mk(KIND_QUERY, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 0,
                        32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff), 1});
    // Unit box at face 0, extreme box at face 255, unused kind ignored.
    rows.push_back('{mk(KIND_LOAD_MIN, 8'd0, 0, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(KIND_LOAD_MAX, 8'd0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0), -1});
    rows.push_back('{mk(KIND_LOAD_MIN, 8'd255, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 0, 0, 0, 0), -1});
    rows.push_back('{mk(KIND_LOAD_MAX, 8'd255, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 0, 0, 0, 0), -1});
    rows.push_back('{mk(kind_e'(2'd3), 8'd7, 1, 2, 3, 4, 5, 6, 7), -1});
    foreach (rows[i]) begin
      send_beat(rows[i].it, 0);
      if (rows[i].expect_hit >= 0 && answers_due[$].reaches !== rows[i].expect_hit[0]) begin
        mismatches++;
        $display("predictor disagrees with directed row %0d", i);
      end
    end
    rows.delete();
    drain();
    write_reg(CFG_BOXES_LOADED, 32'd1);
    write_reg(CFG_PAD_MARGIN, 32'd0);

    // Loaded: containment, slab hits/misses, negative max_t, extreme dirs.
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0), 1});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'h20000, 32'h8000, 32'h8000, 0, 0, 0, 0), 0});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'hfffe_0000, 32'h8000, 32'h8000,
                        32'h10000, 0, 0, 32'h50000), 1});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'hfffe_0000, 32'h8000, 32'h8000,
                        32'h10000, 0, 0, 32'h10000), 0});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'hfffe_0000, 32'h8000, 32'h8000,
                        32'h10000, 0, 0, 32'hffff_0000), 0});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'h8000, 32'h8000, 32'h8000,
                        0, 0, 0, 32'h8000_0000), 1});
    rows.push_back('{mk(KIND_QUERY, 8'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000,
                        32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff), -1});
    rows.push_back('{mk(KIND_QUERY, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 0,
                        1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff), -1});
    rows.push_back('{mk(KIND_QUERY, 8'd255, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff), -1});
    foreach (rows[i]) begin
      send_beat(rows[i].it, $urandom_range(0, 1));
      if (rows[i].expect_hit >= 0 && answers_due[$].reaches !== rows[i].expect_hit[0]) begin
        mismatches++;
        $display("predictor disagrees with loaded row %0d", i);
      end
    end
    // Just outside by 1.0, pad of max value grows every box to cover -2^31+1 up to 2^31-1.
    drain();
    write_reg(CFG_PAD_MARGIN, 32'h7fff_ffff);
    send_beat(mk(KIND_QUERY, 8'd0, 32'h20000, 32'h8000, 32'h8000, 0, 0, 0, 0), 0);
    send_beat(mk(KIND_QUERY, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 5,
                 32'hffff_ffff, 1, 32'h8000_0000, 32'h7fff_ffff), 0);

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_reg(CFG_PAD_MARGIN, 32'd0);
        1: write_reg(CFG_PAD_MARGIN, $urandom_range(0, 32'h0004_0000));
        2: write_reg(CFG_BOXES_LOADED, 32'd0);
        3: begin
          write_reg(CFG_BOXES_LOADED, 32'hffff_fffe); // bit 0 clear
          write_reg(CFG_BOXES_LOADED, 32'd1);
          write_reg(CFG_PAD_MARGIN, 32'h7fff_ffff);
        end
        4: write_reg(CFG_PAD_MARGIN, $urandom() >> 1);
        default: write_reg(CFG_PAD_MARGIN, 32'h0000_8000);
      endcase
      for (int n = 0; n < 130; n++) begin
        if (n == 40) stall_long = 1'b1; // sender keeps pushing into a stalled pipe
        if (n == 100) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (answers_due.size() != 0);
        end
        it = rnd_item();
        // Keep both corners defined: a load fills the other corner on first use.
        if (it.kind inside {KIND_LOAD_MIN, KIND_LOAD_MAX} && !face_loaded[it.face_index]) begin
          in_item_t tw;
          tw = it;
          tw.kind = (it.kind == KIND_LOAD_MIN) ? KIND_LOAD_MAX : KIND_LOAD_MIN;
          send_beat(tw, 0);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        send_beat(it, gap);
      end
    end

    drain();
    out_done = 1'b1;
    $display("covered %0d loads and %0d queries, %0d answers checked, pad/loaded swept",
             loads_sent, queries_sent, answers_seen);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("PASS ray_box_slab_test");
    end else begin
      $display("%0d mismatches, %0d answers missing", mismatches, answers_due.size());
      $display("FAIL ray_box_slab_test");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL ray_box_slab_test");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rbst_pkg.sv
design/rbst_box_mem.sv
design/rbst_div.sv
design/rbst_merge.sv
design/ray_box_slab_test.sv
design/rbst_checker.sv
tb/ray_box_slab_test_tb.sv
